/* rtl/swts_pkg.sv */
// swts_pkg: shared types, codes and the word normalizing function
// for the sorted word table search block; depends on nothing
`timescale 1ns / 1ps

package swts_pkg;

  // word layout: 15 characters, character 0 in the top byte
  localparam int WORD_CHARS  = 15;
  localparam int WORD_BITS   = 8 * WORD_CHARS;
  localparam int HEAD_BITS   = 64;
  localparam int TAIL_BITS   = 56;
  localparam int OUT_COUNT_W = 13;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [HEAD_BITS-1:0] head_t;
  typedef logic [TAIL_BITS-1:0] tail_t;
  typedef logic [OUT_COUNT_W-1:0] out_count_t;

  // action codes of an input beat
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  // status codes of a result beat
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // cut a word at its first zero byte; bytes after it read as zero
  function automatic word_t norm_word(head_t head, tail_t tail);
    word_t raw;
    word_t res;
    logic  alive;
    raw   = {head, tail};
    res   = '0;
    alive = 1'b1;
    for (int i = 0; i < WORD_CHARS; i++) begin
      if (raw[WORD_BITS-1-8*i -: 8] == 8'd0) alive = 1'b0;
      if (alive) res[WORD_BITS-1-8*i -: 8] = raw[WORD_BITS-1-8*i -: 8];
    end
    return res;
  endfunction

endpackage

/* rtl/swts_word_mem.sv */
// swts_word_mem: word store, one write port and one registered read port
// depends on swts_pkg for the word type
`timescale 1ns / 1ps

module swts_word_mem #(
  parameter int MAX_WORDS = 4096,
  localparam int AW = $clog2(MAX_WORDS)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  swts_pkg::word_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output swts_pkg::word_t rd_data
);
  import swts_pkg::*;

  word_t mem [MAX_WORDS];
  word_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/swts_ctrl.sv */
// swts_ctrl: command sequencer, word count and binary search over the store
// depends on swts_pkg; drives the ports of swts_word_mem
`timescale 1ns / 1ps

module swts_ctrl #(
  parameter int MAX_WORDS = 4096,
  localparam int AW = $clog2(MAX_WORDS),
  localparam int CW = $clog2(MAX_WORDS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action,
  input  swts_pkg::word_t      word,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output swts_pkg::word_t      mem_wr_data,
  output logic [AW-1:0]        mem_rd_addr,
  input  swts_pkg::word_t      mem_rd_data,
  output logic                 res_valid,
  output logic                 res_found,
  output logic                 res_status,
  output swts_pkg::out_count_t res_count
);
  import swts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_CMP  = 3'b100
  } state_t;

  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_WORDS);

  state_t        state_r, state_nxt;
  logic [1:0]    act_r, act_nxt;
  word_t         word_r, word_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic          valid_r, valid_nxt;
  logic          found_r, found_nxt;
  logic          status_r, status_nxt;
  out_count_t    ocount_r, ocount_nxt;

  // candidate midpoints for both halves, ready before the compare settles
  logic [CW-1:0] lo_up;
  logic [CW-1:0] mid_lower;
  logic [CW-1:0] mid_upper;
  logic          more_lower;
  logic          more_upper;
  logic          word_lt;
  logic          word_eq;

  assign lo_up      = mid_r + CW'(1);
  assign mid_lower  = lo_r + ((mid_r - lo_r) >> 1);
  assign mid_upper  = lo_up + ((hi_r - lo_up) >> 1);
  assign more_lower = (lo_r < mid_r);
  assign more_upper = (lo_up < hi_r);
  assign word_lt    = (word_r < mem_rd_data);
  assign word_eq    = (word_r == mem_rd_data);

  assign busy = (state_r != ST_IDLE);

  // next state and datapath
  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    word_nxt    = word_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    valid_nxt   = 1'b0;
    found_nxt   = found_r;
    status_nxt  = status_r;
    ocount_nxt  = ocount_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = count_r[AW-1:0];
    mem_wr_data = word_r;
    mem_rd_addr = mid_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = action;
          word_nxt  = word;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        found_nxt  = 1'b0;
        status_nxt = STATUS_DONE;
        case (act_r)
          ACT_APPEND: begin
            if (count_r == FULL_COUNT) begin
              status_nxt = STATUS_FULL;
            end else begin
              mem_wr_en = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          ACT_LOOKUP: begin
            lo_nxt      = '0;
            hi_nxt      = count_r;
            mid_nxt     = count_r >> 1;
            mem_rd_addr = mid_nxt[AW-1:0];
          end
          ACT_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
        if (act_r == ACT_LOOKUP && count_r != '0) begin
          state_nxt = ST_CMP;
        end else begin
          valid_nxt  = 1'b1;
          ocount_nxt = OUT_COUNT_W'(count_nxt);
          state_nxt  = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (word_eq) begin
          found_nxt  = 1'b1;
          valid_nxt  = 1'b1;
          ocount_nxt = OUT_COUNT_W'(count_r);
          state_nxt  = ST_IDLE;
        end else if (word_lt) begin
          hi_nxt      = mid_r;
          mid_nxt     = mid_lower;
          mem_rd_addr = mid_lower[AW-1:0];
          if (!more_lower) begin
            valid_nxt  = 1'b1;
            ocount_nxt = OUT_COUNT_W'(count_r);
            state_nxt  = ST_IDLE;
          end
        end else begin
          lo_nxt      = lo_up;
          mid_nxt     = mid_upper;
          mem_rd_addr = mid_upper[AW-1:0];
          if (!more_upper) begin
            valid_nxt  = 1'b1;
            ocount_nxt = OUT_COUNT_W'(count_r);
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload and search bounds
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    word_r   <= word_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    ocount_r <= ocount_nxt;
  end

  assign res_valid  = valid_r;
  assign res_found  = found_r;
  assign res_status = status_r;
  assign res_count  = ocount_r;

endmodule

/* rtl/sorted_word_table_search.sv */
// sorted_word_table_search: top level, word normalizing and instances
// depends on swts_pkg, swts_ctrl and swts_word_mem
//
//   channel  ports                                     handshake
//   input    in_action, in_word_head, in_word_tail     start high, busy low
//   result   out_found, out_status, out_word_count     out_valid, one cycle
//
// An append, clear or unused action is carried out in the EXEC state, which
// registers its result beat. A lookup on a non-empty table goes on into CMP for
// k halving steps (at most clog2(MAX_WORDS) + 1, 13 for 4096 words):
// each step is one read of the word store and one 120-bit compare.
// Reset clears the state machine and the word count; the store is not cleared.
// busy stays high until the result beat; results cannot be held off.
`timescale 1ns / 1ps

module sorted_word_table_search #(
  parameter int MAX_WORDS = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_action,
  input  swts_pkg::head_t        in_word_head,
  input  swts_pkg::tail_t        in_word_tail,
  output logic                   out_valid,
  output logic                   out_found,
  output logic                   out_status,
  output swts_pkg::out_count_t   out_word_count
);
  import swts_pkg::*;

  localparam int AW = $clog2(MAX_WORDS);

  word_t         in_word;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  word_t         mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  word_t         mem_rd_data;

  // strncmp style word: stops at the first zero byte
  assign in_word = norm_word(in_word_head, in_word_tail);

  // sequencer and search
  swts_ctrl #(
    .MAX_WORDS(MAX_WORDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .action     (in_action),
    .word       (in_word),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .res_valid  (out_valid),
    .res_found  (out_found),
    .res_status (out_status),
    .res_count  (out_word_count)
  );

  // word store
  swts_word_mem #(
    .MAX_WORDS(MAX_WORDS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

/* test/sorted_word_table_search_tb.sv */
// sorted_word_table_search_tb: self-checking bench for the sorted word table search block
// depends on swts_pkg and sorted_word_table_search; holds a scoreboard class that
// mirrors the table and its binary search, and tasks that drive the command port
`timescale 1ns / 1ps

module sorted_word_table_search_tb;
  import swts_pkg::*;

  localparam int          TABLE_DEPTH  = 4096;
  localparam int          RANDOM_BEATS = 750;
  localparam logic [1:0]  ACT_SPARE    = 2'd3;

  // one expected result beat
  typedef struct packed {
    logic       found;
    logic       status;
    out_count_t count;
  } search_reply_t;

  // mirror of the word table; predicts one reply per accepted beat
  class word_table_scoreboard;
    word_t         stored[TABLE_DEPTH];
    int unsigned   held = 0;
    search_reply_t pending[$];
    int unsigned   errors = 0;
    int unsigned   n_appends = 0, n_refused = 0, n_lookups = 0, n_hits = 0;
    int unsigned   n_clears = 0, n_spare = 0, peak = 0;

    // keep the characters before the first zero byte, clear the rest
    function word_t trim_word(head_t head, tail_t tail);
      word_t w;
      word_t ones;
      int    keep;
      w    = {head, tail};
      ones = '1;
      keep = WORD_CHARS;
      for (int i = WORD_CHARS - 1; i >= 0; i--)
        if (w[WORD_BITS-1-8*i -: 8] == 8'h00) keep = i;
      return w & ~(ones >> (8 * keep));
    endfunction

    // exact-match halving search over the entries held
    function logic search_words(word_t key);
      int lo, hi, mid;
      lo = 0;
      hi = int'(held);
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key == stored[mid]) return 1'b1;
        if (key < stored[mid]) hi = mid;
        else lo = mid + 1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic [1:0] act, head_t head, tail_t tail);
      search_reply_t rep;
      word_t         key;
      key        = trim_word(head, tail);
      rep.found  = 1'b0;
      rep.status = STATUS_DONE;
      case (act)
        ACT_APPEND: begin
          n_appends++;
          if (held >= TABLE_DEPTH) begin
            rep.status = STATUS_FULL;
            n_refused++;
          end else begin
            stored[held] = key;
            held++;
            if (held > peak) peak = held;
          end
        end
        ACT_LOOKUP: begin
          n_lookups++;
          rep.found = search_words(key);
          if (rep.found) n_hits++;
        end
        ACT_CLEAR: begin
          n_clears++;
          held = 0;
        end
        default: n_spare++;
      endcase
      rep.count = out_count_t'(held);
      pending.push_back(rep);
    endfunction

    function void check_result(logic found, logic status, out_count_t count);
      search_reply_t want;
      if (pending.size() == 0) begin
        $error("result beat with no beat outstanding: found %0b status %0b word_count %0d",
               found, status, count);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, found);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0b, actual %0b", want.status, status);
        errors++;
      end
      if (count !== want.count) begin
        $error("word_count: expected %0d, actual %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_action = ACT_SPARE;
  head_t      in_word_head = '0;
  tail_t      in_word_tail = '0;
  logic       out_valid;
  logic       out_found;
  logic       out_status;
  out_count_t out_word_count;

  word_table_scoreboard sb;
  bit          steady_phase = 1'b0;
  word_t       last_loaded = '0;
  int unsigned beats_sent = 0;

  sorted_word_table_search #(
    .MAX_WORDS(TABLE_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_word_head  (in_word_head),
    .in_word_tail  (in_word_tail),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_status    (out_status),
    .out_word_count(out_word_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result beats are checked at the edge that ends their cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_found, out_status, out_word_count);
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("sorted_word_table_search_tb: FAIL");
    $finish;
  end

  // character helpers, character 0 in the top byte
  function automatic logic [7:0] char_at(word_t w, int i);
    return w[WORD_BITS-1-8*i -: 8];
  endfunction

  function automatic word_t with_char(word_t w, int i, logic [7:0] c);
    w[WORD_BITS-1-8*i -: 8] = c;
    return w;
  endfunction

  function automatic int word_len(word_t w);
    for (int i = 0; i < WORD_CHARS; i++)
      if (char_at(w, i) == 8'h00) return i;
    return WORD_CHARS;
  endfunction

  // random bits everywhere, sometimes with a zero byte cutting the word short
  function automatic word_t raw_noise();
    word_t w;
    w = word_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    if ($urandom_range(0, 3) == 0)
      w = with_char(w, int'($urandom_range(0, WORD_CHARS - 1)), 8'h00);
    return w;
  endfunction

  // junk after the terminating zero, which the block must ignore
  function automatic word_t with_garbage(word_t w);
    int len;
    len = word_len(w);
    for (int i = len + 1; i < WORD_CHARS; i++)
      w = with_char(w, i, 8'($urandom_range(0, 255)));
    return w;
  endfunction

  // next word above prev (or prev again if all saturated): bump one character, random suffix after it
  function automatic word_t next_sorted_word(word_t prev);
    int          len, top, pos, span, tries, newlen;
    int unsigned bumped;
    word_t       w;
    len = word_len(prev);
    top = (len < WORD_CHARS) ? len : WORD_CHARS - 1;
    pos = -1;
    for (tries = 0; tries < 16 && pos < 0; tries++) begin
      span = int'($urandom_range(0, top));
      if (char_at(prev, span) != 8'hFF) pos = span;
    end
    for (span = top; span >= 0 && pos < 0; span--)
      if (char_at(prev, span) != 8'hFF) pos = span;
    // every character saturated: the word repeats
    if (pos < 0) pos = top;
    bumped = char_at(prev, pos) + $urandom_range(1, 4);
    if (bumped > 255) bumped = 255;
    w      = with_char(prev, pos, 8'(bumped));
    newlen = int'($urandom_range(pos + 1, WORD_CHARS));
    for (int i = pos + 1; i < WORD_CHARS; i++)
      w = with_char(w, i, (i < newlen) ? 8'($urandom_range(1, 255)) : 8'h00);
    return w;
  endfunction

  // a word next to w: one character off, one longer, or one shorter; a full-length word may come back unchanged
  function automatic word_t near_miss(word_t w);
    int         len, pos;
    logic [7:0] ch;
    len = word_len(w);
    if (len == 0) return with_char(w, 0, 8'($urandom_range(1, 255)));
    case ($urandom_range(0, 2))
      0: if (len < WORD_CHARS) w = with_char(w, len, 8'($urandom_range(1, 255)));
      1: w = with_char(w, len - 1, 8'h00);
      default: begin
        pos = int'($urandom_range(0, len - 1));
        ch  = char_at(w, pos);
        if (ch != 8'hFF && (ch == 8'h01 || $urandom_range(0, 1) == 1)) ch = ch + 8'd1;
        else ch = ch - 8'd1;
        w = with_char(w, pos, ch);
      end
    endcase
    return w;
  endfunction

  // one command beat: optional gap, then hold start until the block takes it
  task automatic send_beat(input logic [1:0] act, input word_t raw);
    int unsigned gap;
    gap = steady_phase ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action    = act;
    in_word_head = raw[WORD_BITS-1 -: HEAD_BITS];
    in_word_tail = raw[TAIL_BITS-1:0];
    start        = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_input(act, in_word_head, in_word_tail);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic clear_words();
    send_beat(ACT_CLEAR, raw_noise());
    last_loaded = '0;
  endtask

  // append n words in ascending order
  task automatic load_sorted(input int n);
    repeat (n) begin
      last_loaded = next_sorted_word(last_loaded);
      send_beat(ACT_APPEND, ($urandom_range(0, 1) == 1) ? with_garbage(last_loaded)
                                                         : last_loaded);
    end
  endtask

  // lookup of a held word, a neighbor of one, a bound, or noise
  task automatic probe_lookup();
    word_t       key;
    int unsigned idx, pick;
    pick = $urandom_range(0, 19);
    if (sb.held == 0) begin
      key = (pick < 10) ? word_t'(0) : raw_noise();
    end else begin
      idx = $urandom_range(0, sb.held - 1);
      if (pick == 13) idx = 0;
      if (pick == 14) idx = sb.held - 1;
      key = sb.stored[idx];
      if (pick >= 9 && pick <= 14 && (pick < 13 || $urandom_range(0, 1) == 1))
        key = near_miss(key);
      else if (pick == 15) key = '0;
      else if (pick == 16) key = '1;
      else if (pick >= 17) key = raw_noise();
      if (pick < 15 && $urandom_range(0, 1) == 1) key = with_garbage(key);
    end
    send_beat(ACT_LOOKUP, key);
  endtask

  initial begin
    int unsigned random_base, kind;
    logic [1:0]  act;
    sb = new;

    // synchronous reset
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, the unused code, extreme words, junk after the end
    send_beat(ACT_LOOKUP, '1);
    send_beat(ACT_SPARE, '1);
    send_beat(ACT_CLEAR, '0);
    send_beat(ACT_APPEND, '0);
    send_beat(ACT_APPEND, {8'h41, 8'h00, {104{1'b1}}});
    send_beat(ACT_APPEND, '1);
    send_beat(ACT_LOOKUP, '0);
    send_beat(ACT_LOOKUP, {8'h41, 8'h00, 104'(raw_noise())});
    send_beat(ACT_LOOKUP, {8'h42, 112'h0});
    send_beat(ACT_LOOKUP, '1);
    send_beat(ACT_LOOKUP, {8'h41, 8'h41, 104'h0});
    send_beat(ACT_SPARE, raw_noise());
    send_beat(ACT_CLEAR, '1);

    // directed: words that differ only late in the tail, then an unsorted load
    send_beat(ACT_APPEND, {{14{8'h01}}, 8'h01});
    send_beat(ACT_APPEND, {{14{8'h01}}, 8'h02});
    send_beat(ACT_APPEND, {{8{8'h01}}, 8'h02, 48'h0});
    send_beat(ACT_APPEND, {8'h01, 8'h02, 104'h0});
    send_beat(ACT_LOOKUP, {{14{8'h01}}, 8'h02});
    send_beat(ACT_LOOKUP, {{14{8'h01}}, 8'h03});
    send_beat(ACT_LOOKUP, {{8{8'h01}}, 8'h02, 8'h00, 40'hFF_FFFF_FFFF});
    send_beat(ACT_LOOKUP, {{14{8'h01}}, 8'h00});
    send_beat(ACT_APPEND, {8'h01, 112'h0});
    send_beat(ACT_LOOKUP, {{14{8'h01}}, 8'h01});
    send_beat(ACT_LOOKUP, {8'h01, 112'h0});
    clear_words();

    // fill to capacity, refuse further appends, search the full table
    for (int chunk = 0; chunk < 8; chunk++) begin
      steady_phase = ($urandom_range(0, 1) == 1);
      load_sorted(TABLE_DEPTH / 8);
    end
    steady_phase = 1'b0;
    send_beat(ACT_APPEND, raw_noise());
    send_beat(ACT_APPEND, '0);
    send_beat(ACT_LOOKUP, sb.stored[0]);
    send_beat(ACT_LOOKUP, sb.stored[TABLE_DEPTH-1]);
    send_beat(ACT_LOOKUP, sb.stored[TABLE_DEPTH/2]);
    repeat (40) probe_lookup();
    clear_words();

    // random phases: sorted loads with searches, some noise and clears
    random_base = beats_sent;
    while (beats_sent - random_base < RANDOM_BEATS) begin
      steady_phase = ($urandom_range(0, 3) == 0);
      kind         = $urandom_range(0, 9);
      if (kind == 0) begin
        clear_words();
      end else if (kind <= 5 || kind == 9) begin
        if (kind == 9) clear_words();
        load_sorted(($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 200))
                                                : int'($urandom_range(1, 24)));
        repeat ($urandom_range(4, 30)) probe_lookup();
      end else if (kind <= 7) begin
        repeat ($urandom_range(4, 20)) probe_lookup();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          act = 2'($urandom_range(0, 3));
          send_beat(act, raw_noise());
          if (act == ACT_CLEAR) last_loaded = '0;
        end
      end
    end

    // drain: wait for every reply, then wait on for stray beats
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d beats: %0d appends (%0d refused on a full table), %0d lookups (%0d hits)",
             beats_sent, sb.n_appends, sb.n_refused, sb.n_lookups, sb.n_hits);
    $display("  %0d clears, %0d unused-code beats, table held up to %0d words",
             sb.n_clears, sb.n_spare, sb.peak);
    if (sb.errors == 0) begin
      $display("sorted_word_table_search_tb: PASS");
    end else begin
      $display("sorted_word_table_search_tb: FAIL");
    end
    $finish;
  end

endmodule
